@@ design/bat_pkg.sv @@
`timescale 1ns / 1ps

package bat_pkg;

	localparam int BLOCKS      = 1024;
	localparam int BLOCK_BYTES = 32;

	localparam int POOL_BYTES = BLOCKS * BLOCK_BYTES;
	localparam int IDX_W      = $clog2(BLOCKS);
	localparam int CNT_W      = $clog2(BLOCKS + 1);
	localparam int NEED_W     = $clog2((65535 + BLOCK_BYTES - 1) / BLOCK_BYTES + 1);

	localparam int SIZE_W    = 16;
	localparam int OFF_W     = 15;
	localparam int PCT_W     = 7;
	localparam int STAT_W    = 2;
	localparam int IN_DATA_W = 32;
	localparam int OUT_W     = 24;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK         = 2'd0,
		STAT_ALLOC_FAIL = 2'd1,
		STAT_RANGE      = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_DECODE,
		S_SCAN,
		S_MARK,
		S_FREE_CNT,
		S_FREE_CLR,
		S_RESULT
	} state_t;

	typedef enum logic [2:0] {
		PTR_HOLD,
		PTR_INC,
		PTR_DEC,
		PTR_TOP,
		PTR_START
	} ptr_op_t;

	typedef enum logic [2:0] {
		RD_PTR,
		RD_INC,
		RD_DEC,
		RD_TOP,
		RD_START
	} rd_sel_t;

	typedef enum logic [1:0] {
		CNT_HOLD,
		CNT_NEED,
		CNT_CLAMP,
		CNT_DEC
	} cnt_op_t;

	typedef struct packed {
		logic    load;
		ptr_op_t ptr_op;
		rd_sel_t rd_sel;
		logic    wr_en;
		logic    wr_need;
		logic    run_clr;
		logic    run_upd;
		logic    base_load;
		cnt_op_t cnt_op;
		logic    used_add;
		logic    used_sub;
		logic    res_load;
		status_t res_code;
		logic    res_off_en;
	} dp_cmd_t;

	typedef struct packed {
		logic is_free;
		logic need_bad;
		logic range_bad;
		logic scan_hit;
		logic scan_last;
		logic cnt_none;
		logic cnt_last;
		logic sweep_last;
		logic out_busy;
	} dp_stat_t;

endpackage

@@ design/bat_ctrl.sv @@
`timescale 1ns / 1ps

module bat_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  bat_pkg::dp_stat_t stat,
	output bat_pkg::dp_cmd_t  cmd
);
	import bat_pkg::*;

	state_t  state_q, state_d;
	status_t code_q, code_d;
	logic    off_q, off_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			code_q  <= STAT_OK;
			off_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			code_q  <= code_d;
			off_q   <= off_d;
		end
	end

	always_comb begin
		state_d        = state_q;
		code_d         = code_q;
		off_d          = off_q;
		s_axis_tready  = 1'b0;
		cmd            = '0;
		cmd.ptr_op     = PTR_HOLD;
		cmd.rd_sel     = RD_PTR;
		cmd.cnt_op     = CNT_HOLD;
		cmd.res_code   = STAT_OK;
		case (state_q)
			S_CLEAR: begin
				// Sweep the whole table to zero once after reset.
				cmd.wr_en  = 1'b1;
				cmd.ptr_op = PTR_INC;
				if (stat.sweep_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					cmd.load = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				off_d = 1'b0;
				if (stat.is_free) begin
					if (stat.range_bad) begin
						code_d  = STAT_RANGE;
						state_d = S_RESULT;
					end else begin
						cmd.ptr_op = PTR_START;
						cmd.rd_sel = RD_START;
						state_d    = S_FREE_CNT;
					end
				end else begin
					if (stat.need_bad) begin
						code_d  = STAT_ALLOC_FAIL;
						state_d = S_RESULT;
					end else begin
						cmd.ptr_op  = PTR_TOP;
						cmd.rd_sel  = RD_TOP;
						cmd.run_clr = 1'b1;
						state_d     = S_SCAN;
					end
				end
			end
			S_SCAN: begin
				cmd.run_upd = 1'b1;
				if (stat.scan_hit) begin
					cmd.base_load = 1'b1;
					cmd.cnt_op    = CNT_NEED;
					cmd.used_add  = 1'b1;
					state_d       = S_MARK;
				end else if (stat.scan_last) begin
					code_d  = STAT_ALLOC_FAIL;
					state_d = S_RESULT;
				end else begin
					cmd.ptr_op = PTR_DEC;
					cmd.rd_sel = RD_DEC;
				end
			end
			S_MARK: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_need = 1'b1;
				cmd.ptr_op  = PTR_INC;
				cmd.cnt_op  = CNT_DEC;
				if (stat.cnt_last) begin
					code_d  = STAT_OK;
					off_d   = 1'b1;
					state_d = S_RESULT;
				end
			end
			S_FREE_CNT: begin
				cmd.cnt_op = CNT_CLAMP;
				if (stat.cnt_none) begin
					code_d  = STAT_OK;
					state_d = S_RESULT;
				end else begin
					state_d = S_FREE_CLR;
				end
			end
			S_FREE_CLR: begin
				// Clear the entry just read while fetching the next one up.
				cmd.wr_en    = 1'b1;
				cmd.used_sub = 1'b1;
				cmd.ptr_op   = PTR_INC;
				cmd.rd_sel   = RD_INC;
				cmd.cnt_op   = CNT_DEC;
				if (stat.cnt_last) begin
					code_d  = STAT_OK;
					state_d = S_RESULT;
				end
			end
			S_RESULT: begin
				if (!stat.out_busy) begin
					cmd.res_load   = 1'b1;
					cmd.res_code   = code_q;
					cmd.res_off_en = off_q;
					state_d        = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

@@ design/bat_dpath.sv @@
`timescale 1ns / 1ps

module bat_dpath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [bat_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // req_size, free_offset
	input  logic [0:0]                     s_axis_tuser,  // cmd
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [bat_pkg::OUT_W-1:0]      m_axis_tdata,  // status, alloc_offset, used_percent
	input  bat_pkg::dp_cmd_t               cmd,
	output bat_pkg::dp_stat_t              stat
);
	import bat_pkg::*;

	logic [CNT_W-1:0]  tbl_q [BLOCKS];
	logic [CNT_W-1:0]  rd_q;
	logic [IDX_W-1:0]  rd_addr;
	logic [CNT_W-1:0]  wr_data;

	logic              is_free_q;
	logic [NEED_W-1:0] need_q;
	logic [IDX_W-1:0]  start_q;
	logic              range_bad_q;

	logic [IDX_W-1:0]  ptr_q;
	logic [IDX_W-1:0]  base_q;
	logic [CNT_W-1:0]  run_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  used_q;

	logic [CNT_W-1:0]  limit;
	logic [CNT_W-1:0]  clamp;
	logic [CNT_W-1:0]  need_cnt;

	logic              out_vld_q;
	status_t           out_stat_q;
	logic [OFF_W-1:0]  out_off_q;
	logic [PCT_W-1:0]  out_pct_q;

	wire [SIZE_W-1:0] req_size    = s_axis_tdata[SIZE_W-1:0];
	wire [SIZE_W-1:0] free_offset = s_axis_tdata[2*SIZE_W-1:SIZE_W];

	assign need_cnt = CNT_W'(need_q);
	assign limit    = CNT_W'(BLOCKS) - CNT_W'(start_q);
	assign clamp    = (rd_q < limit) ? rd_q : limit;

	always_comb begin
		case (cmd.rd_sel)
			RD_PTR:   rd_addr = ptr_q;
			RD_INC:   rd_addr = ptr_q + IDX_W'(1);
			RD_DEC:   rd_addr = ptr_q - IDX_W'(1);
			RD_TOP:   rd_addr = IDX_W'(BLOCKS - 1);
			RD_START: rd_addr = start_q;
			default:  rd_addr = ptr_q;
		endcase
	end

	assign wr_data = cmd.wr_need ? need_cnt : '0;

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			tbl_q[ptr_q] <= wr_data;
		end
		rd_q <= tbl_q[rd_addr];
	end

	// Request fields; the block count is rounded up when the item is taken.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			is_free_q   <= s_axis_tuser[0];
			need_q      <= NEED_W'((32'(req_size) + BLOCK_BYTES - 1) / BLOCK_BYTES);
			range_bad_q <= 32'(free_offset) >= POOL_BYTES;
			start_q     <= IDX_W'(32'(free_offset) / BLOCK_BYTES);
		end
		if (cmd.base_load) begin
			base_q <= ptr_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q  <= '0;
			run_q  <= '0;
			cnt_q  <= '0;
			used_q <= '0;
		end else begin
			case (cmd.ptr_op)
				PTR_HOLD:  ptr_q <= ptr_q;
				PTR_INC:   ptr_q <= ptr_q + IDX_W'(1);
				PTR_DEC:   ptr_q <= ptr_q - IDX_W'(1);
				PTR_TOP:   ptr_q <= IDX_W'(BLOCKS - 1);
				PTR_START: ptr_q <= start_q;
				default:   ptr_q <= ptr_q;
			endcase
			if (cmd.run_clr) begin
				run_q <= '0;
			end else if (cmd.run_upd) begin
				run_q <= (rd_q == '0) ? run_q + CNT_W'(1) : '0;
			end
			case (cmd.cnt_op)
				CNT_HOLD:  cnt_q <= cnt_q;
				CNT_NEED:  cnt_q <= need_cnt;
				CNT_CLAMP: cnt_q <= clamp;
				CNT_DEC:   cnt_q <= cnt_q - CNT_W'(1);
				default:   cnt_q <= cnt_q;
			endcase
			if (cmd.used_add) begin
				used_q <= used_q + need_cnt;
			end else if (cmd.used_sub && rd_q != '0) begin
				used_q <= used_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.res_load) begin
			out_vld_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			out_stat_q <= cmd.res_code;
			out_off_q  <= cmd.res_off_en ? OFF_W'(32'(base_q) * BLOCK_BYTES) : '0;
			out_pct_q  <= PCT_W'((32'(used_q) * 32'd100) / BLOCKS);
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {out_pct_q, out_off_q, out_stat_q};

	assign stat.is_free    = is_free_q;
	assign stat.need_bad   = (need_q == '0) || (32'(need_q) > BLOCKS);
	assign stat.range_bad  = range_bad_q;
	assign stat.scan_hit   = (rd_q == '0) && (32'(run_q) + 32'd1 == 32'(need_q));
	assign stat.scan_last  = (ptr_q == '0);
	assign stat.cnt_none   = (clamp == '0);
	assign stat.cnt_last   = (cnt_q == CNT_W'(1));
	assign stat.sweep_last = (ptr_q == IDX_W'(BLOCKS - 1));
	assign stat.out_busy   = out_vld_q && !m_axis_tready;

`ifndef ASSERT_OFF
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(used_q) <= BLOCKS)
		else $error("used block count exceeds table size");

	a_res_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |-> !(out_vld_q && !m_axis_tready))
		else $error("result loaded over a pending transaction");

	a_mark_len: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.wr_en && cmd.wr_need) |-> (need_q != '0 && 32'(need_q) <= BLOCKS))
		else $error("run marked with an invalid length");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.used_sub && rd_q != '0) |-> used_q != '0)
		else $error("used block count underflow");

	a_add_fits: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.used_add |=> 32'(used_q) == 32'($past(used_q)) + 32'($past(need_q)))
		else $error("used block count lost an allocation");
`endif

endmodule

@@ design/block_allocation_table.sv @@
`timescale 1ns / 1ps

// Channel   Direction  tdata fields (low bit up)               tuser
// s_axis    in         req_size[15:0], free_offset[31:16]      cmd
// m_axis    out        status[1:0], alloc_offset[16:2],        -
//                      used_percent[23:17]
//
// Allocate scans the table for a long enough run of free entries, then marks that run.
// Free clears the entries of the run at free_offset; both walk the table one entry per cycle.
// After reset a clearing pass zeroes the whole table; s_axis_tready stays low meanwhile.
// A result waits in the output register; the next item is accepted meanwhile,
// and its result stalls until the previous transaction is taken.
module block_allocation_table (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [bat_pkg::IN_DATA_W-1:0] s_axis_tdata,  // req_size, free_offset
	input  logic [0:0]                    s_axis_tuser,  // cmd
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [bat_pkg::OUT_W-1:0]     m_axis_tdata   // status, alloc_offset, used_percent
);
	import bat_pkg::*;

	dp_cmd_t  dp_cmd;
	dp_stat_t dp_stat;

	bat_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.stat          (dp_stat),
		.cmd           (dp_cmd)
	);

	bat_dpath u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cmd           (dp_cmd),
		.stat          (dp_stat)
	);

endmodule
